// ===== hdl/hsgc_pkg.sv =====
`timescale 1ns / 1ps

package hsgc_pkg;

    // Register map (byte address = 4 * index)
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned MODE_W   = 3;

    localparam logic [1:0] REG_STABLE_TIME = 2'd0;
    localparam logic [1:0] REG_SHORT_PRESS = 2'd1;
    localparam logic [1:0] REG_LONG_HOLD   = 2'd2;
    localparam logic [1:0] REG_BOOT_IGNORE = 2'd3;

    localparam logic [CFG_W-1:0] RST_STABLE_TIME = 16'd20;
    localparam logic [CFG_W-1:0] RST_SHORT_PRESS = 16'd300;
    localparam logic [CFG_W-1:0] RST_LONG_HOLD   = 16'd2000;
    localparam logic [CFG_W-1:0] RST_BOOT_IGNORE = 16'd1500;

    // System mode codes
    localparam logic [MODE_W-1:0] SYS_IDLE      = 3'd0;
    localparam logic [MODE_W-1:0] SYS_WAIT_SATS = 3'd1;
    localparam logic [MODE_W-1:0] SYS_LOGGING   = 3'd2;
    localparam logic [MODE_W-1:0] SYS_CONFIG    = 3'd3;
    localparam logic [MODE_W-1:0] SYS_SLEEP     = 3'd4;

    // Item kind codes
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] stable_time_ms;
        logic [CFG_W-1:0] short_min_ms;
        logic [CFG_W-1:0] long_hold_ms;
        logic [CFG_W-1:0] ignore_win_ms;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [TS_W-1:0]   now_ms;
        logic              pin_level;
        logic [MODE_W-1:0] current_mode;
        logic              woke_flag;
    } t_item;

    typedef struct packed {
        logic              stable_active;
        logic              edge_notice;
        logic              mode_request_valid;
        logic [MODE_W-1:0] requested_mode;
        logic              clear_wake;
    } t_result;

    typedef struct packed {
        logic [TS_W-1:0] window_start;
        logic [TS_W-1:0] press_start;
        logic [TS_W-1:0] change_start;
        logic            change_armed;
        logic            wait_release;
        logic            long_done;
        logic            sleep_pending;
        logic            level_now;
        logic            level_before;
    } t_state;

endpackage

// ===== hdl/hsgc_item_if.sv =====
`timescale 1ns / 1ps

interface hsgc_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_ms;
    logic        pin_level;
    logic [2:0]  current_mode;
    logic        woke_flag;

    modport source (output valid, kind, now_ms, pin_level, current_mode, woke_flag,
                    input ready);
    modport sink   (input valid, kind, now_ms, pin_level, current_mode, woke_flag,
                    output ready);
endinterface

// ===== hdl/hsgc_result_if.sv =====
`timescale 1ns / 1ps

interface hsgc_result_if;
    logic       valid;
    logic       ready;
    logic       stable_active;
    logic       edge_notice;
    logic       mode_request_valid;
    logic [2:0] requested_mode;
    logic       clear_wake;

    modport source (output valid, stable_active, edge_notice, mode_request_valid,
                    requested_mode, clear_wake, input ready);
    modport sink   (input valid, stable_active, edge_notice, mode_request_valid,
                    requested_mode, clear_wake, output ready);
endinterface

// ===== hdl/hsgc_cfg_regs.sv =====
`timescale 1ns / 1ps

module hsgc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsgc_pkg::APB_AW-1:0] paddr,
    input  logic [hsgc_pkg::APB_DW-1:0] pwdata,
    output logic [hsgc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output hsgc_pkg::t_cfg              o_cfg
);
    import hsgc_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    // register write on access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_time_ms <= RST_STABLE_TIME;
            r_cfg.short_min_ms   <= RST_SHORT_PRESS;
            r_cfg.long_hold_ms   <= RST_LONG_HOLD;
            r_cfg.ignore_win_ms  <= RST_BOOT_IGNORE;
        end else if (w_wr) begin
            case (w_idx)
                REG_STABLE_TIME: r_cfg.stable_time_ms <= pwdata[CFG_W-1:0];
                REG_SHORT_PRESS: r_cfg.short_min_ms   <= pwdata[CFG_W-1:0];
                REG_LONG_HOLD:   r_cfg.long_hold_ms   <= pwdata[CFG_W-1:0];
                REG_BOOT_IGNORE: r_cfg.ignore_win_ms  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_STABLE_TIME: prdata[CFG_W-1:0] = r_cfg.stable_time_ms;
            REG_SHORT_PRESS: prdata[CFG_W-1:0] = r_cfg.short_min_ms;
            REG_LONG_HOLD:   prdata[CFG_W-1:0] = r_cfg.long_hold_ms;
            REG_BOOT_IGNORE: prdata[CFG_W-1:0] = r_cfg.ignore_win_ms;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/hsgc_engine.sv =====
`timescale 1ns / 1ps

module hsgc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  hsgc_pkg::t_cfg    i_cfg,
    input  hsgc_pkg::t_item   i_item,
    output hsgc_pkg::t_result o_result
);
    import hsgc_pkg::*;

    t_state          r_state;
    t_state          n_state;
    t_result         w_res;
    logic [TS_W-1:0] w_win_base;
    logic [TS_W-1:0] w_win_diff;
    logic [TS_W-1:0] w_chg_diff;
    logic [TS_W-1:0] w_press_diff;
    logic            w_in_window;
    logic            w_stable_ok;
    logic            w_short_ok;
    logic            w_raw;
    logic            w_rise;
    logic            w_fall;

    // time differences, all modulo 2^32
    assign w_win_base   = r_state.wait_release ? i_item.now_ms : r_state.window_start;
    assign w_win_diff   = i_item.now_ms - w_win_base;
    assign w_chg_diff   = i_item.now_ms - r_state.change_start;
    assign w_press_diff = i_item.now_ms - r_state.press_start;
    assign w_in_window  = w_win_diff < {{(TS_W-CFG_W){1'b0}}, i_cfg.ignore_win_ms};
    assign w_stable_ok  = w_chg_diff >= {{(TS_W-CFG_W){1'b0}}, i_cfg.stable_time_ms};
    assign w_short_ok   = w_press_diff >= {{(TS_W-CFG_W){1'b0}}, i_cfg.short_min_ms};
    assign w_raw        = !i_item.pin_level;

    // one item's state update and result
    always_comb begin
        n_state = r_state;
        w_res   = '0;
        w_rise  = 1'b0;
        w_fall  = 1'b0;
        if (i_item.kind == KIND_INIT) begin
            n_state.window_start = i_item.now_ms;
            if (i_item.woke_flag) begin
                n_state.wait_release  = 1'b1;
                n_state.press_start   = '0;
                n_state.long_done     = 1'b0;
                n_state.sleep_pending = 1'b0;
            end
        end else if (!(r_state.wait_release && !i_item.pin_level)) begin
            // wake wait ends on release and restarts the window
            if (r_state.wait_release) begin
                n_state.wait_release = 1'b0;
                n_state.window_start = i_item.now_ms;
                w_res.clear_wake     = 1'b1;
            end
            if (!w_in_window) begin
                // debounce
                if (w_raw != r_state.level_now) begin
                    if (!r_state.change_armed) begin
                        n_state.change_armed = 1'b1;
                        n_state.change_start = i_item.now_ms;
                    end else if (w_stable_ok) begin
                        n_state.level_now    = w_raw;
                        n_state.change_armed = 1'b0;
                    end
                end else begin
                    n_state.change_armed = 1'b0;
                end

                w_res.edge_notice = n_state.level_now != r_state.level_before;
                w_rise = n_state.level_now && !r_state.level_before;
                w_fall = !n_state.level_now && r_state.level_before;

                // press edge starts hold timer
                if (w_rise) begin
                    n_state.press_start   = i_item.now_ms;
                    n_state.long_done     = 1'b0;
                    n_state.sleep_pending = 1'b0;
                end

                // long hold
                if (n_state.level_now && !n_state.long_done &&
                    ((w_rise ? '0 : w_press_diff) >=
                     {{(TS_W-CFG_W){1'b0}}, i_cfg.long_hold_ms})) begin
                    n_state.long_done = 1'b1;
                    case (i_item.current_mode)
                        SYS_IDLE: begin
                            w_res.mode_request_valid = 1'b1;
                            w_res.requested_mode     = SYS_CONFIG;
                        end
                        SYS_LOGGING, SYS_WAIT_SATS: begin
                            n_state.sleep_pending = 1'b1;
                        end
                        default: ;
                    endcase
                end

                // release
                if (w_fall) begin
                    if (n_state.long_done) begin
                        if (n_state.sleep_pending) begin
                            n_state.sleep_pending    = 1'b0;
                            w_res.mode_request_valid = 1'b1;
                            w_res.requested_mode     = SYS_SLEEP;
                        end
                    end else if (w_short_ok) begin
                        case (i_item.current_mode)
                            SYS_IDLE: begin
                                w_res.mode_request_valid = 1'b1;
                                w_res.requested_mode     = SYS_WAIT_SATS;
                            end
                            SYS_LOGGING, SYS_WAIT_SATS: begin
                                w_res.mode_request_valid = 1'b1;
                                w_res.requested_mode     = SYS_SLEEP;
                            end
                            SYS_CONFIG: begin
                                w_res.mode_request_valid = 1'b1;
                                w_res.requested_mode     = SYS_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end

                n_state.level_before = n_state.level_now;
            end
        end
        w_res.stable_active = n_state.level_now;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_result = w_res;

    // a release during the wake wait always drops the wait
    a_wake_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_res.clear_wake |=> !r_state.wait_release)
        else $error("wait_release still set after clear_wake");

endmodule

// ===== hdl/hall_switch_gesture_controller_core.sv =====
`timescale 1ns / 1ps

// Magnet switch gesture controller. Takes one word (init event or poll sample)
// per clock cycle while the result channel keeps up, and returns exactly one
// result word for each, registered first in the input register and then in
// the result register. The sustained rate of one word per cycle is set by the
// state update in the engine, which closes on itself from one word to the next.
// The result register stalls only when the result channel is not ready.
// Timing thresholds are 16-bit APB registers at byte addresses 0, 4, 8 and 12
// (stable time, short press minimum, long hold, boot ignore); write them only
// while no word is in flight.
module hall_switch_gesture_controller_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hsgc_item_if.sink                   i_item,
    hsgc_result_if.source               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsgc_pkg::APB_AW-1:0] paddr,
    input  logic [hsgc_pkg::APB_DW-1:0] pwdata,
    output logic [hsgc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import hsgc_pkg::*;

    t_cfg    w_cfg;
    t_item   r_s1;
    logic    r_s1_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    logic    w_adv;
    logic    w_in_acc;

    hsgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hsgc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_cfg    (w_cfg),
        .i_item   (r_s1),
        .o_result (w_res)
    );

    // handshake
    assign w_adv        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_adv;
    assign w_in_acc     = i_item.valid && i_item.ready;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1.kind         <= i_item.kind;
            r_s1.now_ms       <= i_item.now_ms;
            r_s1.pin_level    <= i_item.pin_level;
            r_s1.current_mode <= i_item.current_mode;
            r_s1.woke_flag    <= i_item.woke_flag;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.stable_active      = r_out.stable_active;
    assign o_result.edge_notice        = r_out.edge_notice;
    assign o_result.mode_request_valid = r_out.mode_request_valid;
    assign o_result.requested_mode     = r_out.requested_mode;
    assign o_result.clear_wake         = r_out.clear_wake;

    // an accepted word always lands in the input register
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted word missing from input register");

    // a held word stays put until the engine takes it
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_s1))
        else $error("input register word lost while stalled");

    // an engine step always produces a result word
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("engine step without result word");

endmodule
